### hw/rtl/cor_pkg.sv
// Shared types and helpers for the circle overlap resolver.
// Used by cor_iter and circle_overlap_resolver_top; no dependencies.
`default_nettype none
package cor_pkg;

   // Operation of the shared iterative unit.
   typedef enum logic {
      ITER_DIV  = 1'b0,
      ITER_SQRT = 1'b1
   } iter_mode_type;

   // Command word from the sequencer to the iterative unit.
   typedef struct packed {
      logic          start;
      iter_mode_type mode;
      logic [63:0]   num;
      logic [31:0]   den;
   } iter_cmd_type;

   // Status word from the iterative unit back to the sequencer.
   typedef struct packed {
      logic        done;
      logic [47:0] result;
   } iter_stat_type;

   localparam int QUOT_STEPS = 48;
   localparam int ROOT_STEPS = 32;

   // Clamp a 36-bit signed value to the signed 32-bit range.
   function automatic logic [31:0] sat_word(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > 36'sh07FFFFFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -36'sh080000000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/circle_overlap_resolver_top.sv
// Top level of the circle overlap resolver: body store, pair sequencer,
// shared multiplier and output register. Depends on cor_pkg and cor_iter.
//
// Bodies are loaded one word per cycle while the block is idle. A word with
// last_body set starts the pair sweep over all pairs i<j in load order; each
// pair is read from the body memory, tested, and if it overlaps it passes
// through one integer square root and four divisions on a single shared
// iterative unit, plus nine passes through one shared 33x33 multiplier. A
// pair rejected by the axis, radius and mass test stops at S_TEST, one
// rejected by the distance compare at S_CMP; when the centers coincide the
// two normal divisions are skipped, since the normal then needs no division.
// After the sweep one result word per body is issued in index order. The
// input stays stalled from the last body until the final result word is
// taken. A body arriving when the set is full is dropped.
`default_nettype none
module circle_overlap_resolver_top #(
   parameter int MAX_BODIES = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_pos_x,
   input  wire  [31:0] req_pos_y,
   input  wire  [30:0] req_radius,
   input  wire  [15:0] req_mass_value,
   input  wire  [15:0] req_size_value,
   input  wire         req_last_body,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [5:0]  rsp_body_index,
   output logic [31:0] rsp_new_x,
   output logic [31:0] rsp_new_y,
   output logic        rsp_last_result
);
   import cor_pkg::*;

   localparam int AW = $clog2(MAX_BODIES);
   localparam int CW = AW + 1;

   typedef enum logic [25:0] {
      S_IDLE      = 26'h0000001,
      S_RD_I      = 26'h0000002,
      S_RD_J      = 26'h0000004,
      S_DIFF      = 26'h0000008,
      S_TEST      = 26'h0000010,
      S_MUL_A     = 26'h0000020,
      S_MUL_B     = 26'h0000040,
      S_MUL_R     = 26'h0000080,
      S_CMP       = 26'h0000100,
      S_SQRT      = 26'h0000200,
      S_DIV_NX    = 26'h0000400,
      S_DIV_NY    = 26'h0000800,
      S_MUL_OI    = 26'h0001000,
      S_DIV_MI    = 26'h0002000,
      S_MUL_OJ    = 26'h0004000,
      S_DIV_MJ    = 26'h0008000,
      S_MUL_XI    = 26'h0010000,
      S_MUL_YI    = 26'h0020000,
      S_MUL_XJ    = 26'h0040000,
      S_MUL_YJ    = 26'h0080000,
      S_WR_I      = 26'h0100000,
      S_WR_J      = 26'h0200000,
      S_NEXT      = 26'h0400000,
      S_EMIT_RD   = 26'h0800000,
      S_EMIT_LD   = 26'h1000000,
      S_EMIT_WAIT = 26'h2000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in, e_ff, e_in;
   logic          issued_ff, issued_in;

   logic [31:0] xi_ff, xi_in, yi_ff, yi_in, xj_ff, xj_in, yj_ff, yj_in;
   logic [30:0] ri_ff, ri_in;
   logic [15:0] mi_ff, mi_in, mj_ff, mj_in;
   logic [31:0] ax_ff, ax_in, ay_ff, ay_in, rsum_ff, rsum_in;
   logic        dxneg_ff, dxneg_in, dyneg_ff, dyneg_in;
   logic [16:0] msum_ff, msum_in;
   logic [63:0] a2_ff, a2_in, b2_ff, b2_in, r2_ff, r2_in, sum_ff, sum_in;
   logic [31:0] dist_ff, dist_in;
   logic [16:0] nxm_ff, nxm_in, nym_ff, nym_in;
   logic [47:0] p_ff, p_in;
   logic [31:0] mvi_ff, mvi_in, mvj_ff, mvj_in;
   logic [48:0] dxi_ff, dxi_in, dyi_ff, dyi_in, dxj_ff, dxj_in, dyj_ff, dyj_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  oidx_ff, oidx_in;
   logic [31:0] ox_ff, ox_in, oy_ff, oy_in;
   logic        olast_ff, olast_in;

   // Body memories with registered read data.
   logic [31:0] mem_x_ff [MAX_BODIES];
   logic [31:0] mem_y_ff [MAX_BODIES];
   logic [30:0] mem_r_ff [MAX_BODIES];
   logic [15:0] mem_m_ff [MAX_BODIES];
   logic [31:0] rd_x_ff, rd_y_ff;
   logic [30:0] rd_r_ff;
   logic [15:0] rd_m_ff;

   logic          wr_xy, wr_rm;
   logic [AW-1:0] waddr, raddr;
   logic [31:0]   wx, wy;
   logic [15:0]   eff_mass;

   logic [32:0] mul_a, mul_b;
   logic [65:0] prod;
   logic [32:0] dx, dy, ovl;
   logic [64:0] sum_w;
   logic [CW-1:0] jn, i2, en;
   logic        accept;

   iter_cmd_type  cmd;
   iter_stat_type stat;

   cor_iter u_iter (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign eff_mass  = (req_mass_value != 16'd0) ? req_mass_value : req_size_value;

   // Memory address and write selection.
   always_comb begin
      raddr = i_ff;
      if (state_ff == S_RD_J) begin
         raddr = j_ff;
      end else if (state_ff == S_EMIT_RD) begin
         raddr = e_ff;
      end
   end

   always_comb begin
      wr_xy = 1'b0;
      wr_rm = 1'b0;
      waddr = count_ff[AW-1:0];
      wx    = req_pos_x;
      wy    = req_pos_y;
      if (accept && (count_ff < CW'(MAX_BODIES))) begin
         wr_xy = 1'b1;
         wr_rm = 1'b1;
      end else if (state_ff == S_WR_I) begin
         wr_xy = 1'b1;
         waddr = i_ff;
         wx = sat_word(dxneg_ff ? $signed({{4{xi_ff[31]}}, xi_ff}) + $signed({3'b0, dxi_ff[48:16]})
                                : $signed({{4{xi_ff[31]}}, xi_ff}) - $signed({3'b0, dxi_ff[48:16]}));
         wy = sat_word(dyneg_ff ? $signed({{4{yi_ff[31]}}, yi_ff}) + $signed({3'b0, dyi_ff[48:16]})
                                : $signed({{4{yi_ff[31]}}, yi_ff}) - $signed({3'b0, dyi_ff[48:16]}));
      end else if (state_ff == S_WR_J) begin
         wr_xy = 1'b1;
         waddr = j_ff;
         wx = sat_word(dxneg_ff ? $signed({{4{xj_ff[31]}}, xj_ff}) - $signed({3'b0, dxj_ff[48:16]})
                                : $signed({{4{xj_ff[31]}}, xj_ff}) + $signed({3'b0, dxj_ff[48:16]}));
         wy = sat_word(dyneg_ff ? $signed({{4{yj_ff[31]}}, yj_ff}) - $signed({3'b0, dyj_ff[48:16]})
                                : $signed({{4{yj_ff[31]}}, yj_ff}) + $signed({3'b0, dyj_ff[48:16]}));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_xy) begin
         mem_x_ff[waddr] <= wx;
         mem_y_ff[waddr] <= wy;
      end
      if (wr_rm) begin
         mem_r_ff[waddr] <= req_radius;
         mem_m_ff[waddr] <= eff_mass;
      end
      rd_x_ff <= mem_x_ff[raddr];
      rd_y_ff <= mem_y_ff[raddr];
      rd_r_ff <= mem_r_ff[raddr];
      rd_m_ff <= mem_m_ff[raddr];
   end

   // Shared multiplier operand selection.
   assign ovl = {1'b0, rsum_ff - dist_ff};
   always_comb begin
      mul_a = {1'b0, ax_ff};
      mul_b = {1'b0, ax_ff};
      case (state_ff)
         S_MUL_B:  begin mul_a = {1'b0, ay_ff};   mul_b = {1'b0, ay_ff};   end
         S_MUL_R:  begin mul_a = {1'b0, rsum_ff}; mul_b = {1'b0, rsum_ff}; end
         S_MUL_OI: begin mul_a = ovl;             mul_b = {17'b0, mj_ff};  end
         S_MUL_OJ: begin mul_a = ovl;             mul_b = {17'b0, mi_ff};  end
         S_MUL_XI: begin mul_a = {16'b0, nxm_ff}; mul_b = {1'b0, mvi_ff};  end
         S_MUL_YI: begin mul_a = {16'b0, nym_ff}; mul_b = {1'b0, mvi_ff};  end
         S_MUL_XJ: begin mul_a = {16'b0, nxm_ff}; mul_b = {1'b0, mvj_ff};  end
         S_MUL_YJ: begin mul_a = {16'b0, nym_ff}; mul_b = {1'b0, mvj_ff};  end
         default:  begin mul_a = {1'b0, ax_ff};   mul_b = {1'b0, ax_ff};   end
      endcase
   end
   assign prod = mul_a * mul_b;

   // Iterative unit command.
   always_comb begin
      cmd.start = 1'b0;
      cmd.mode  = ITER_DIV;
      cmd.num   = {p_ff, 16'b0};
      cmd.den   = {15'b0, msum_ff};
      case (state_ff)
         S_SQRT: begin
            cmd.mode = ITER_SQRT;
            cmd.num  = sum_ff;
         end
         S_DIV_NX: begin
            cmd.num = {ax_ff, 32'b0};
            cmd.den = dist_ff;
         end
         S_DIV_NY: begin
            cmd.num = {ay_ff, 32'b0};
            cmd.den = dist_ff;
         end
         default: begin
            cmd.num = {p_ff, 16'b0};
         end
      endcase
      cmd.start = !issued_ff && ((state_ff == S_SQRT) || (state_ff == S_DIV_NX) ||
                  (state_ff == S_DIV_NY) || (state_ff == S_DIV_MI) || (state_ff == S_DIV_MJ));
   end

   assign dx    = {rd_x_ff[31], rd_x_ff} - {xi_ff[31], xi_ff};
   assign dy    = {rd_y_ff[31], rd_y_ff} - {yi_ff[31], yi_ff};
   assign sum_w = {1'b0, a2_ff} + {1'b0, b2_ff};
   assign jn    = {1'b0, j_ff} + CW'(1);
   assign i2    = {1'b0, i_ff} + CW'(2);
   assign en    = {1'b0, e_ff} + CW'(1);

   // Pair sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      e_in = e_ff;
      issued_in = issued_ff;
      xi_in = xi_ff; yi_in = yi_ff; xj_in = xj_ff; yj_in = yj_ff;
      ri_in = ri_ff; mi_in = mi_ff; mj_in = mj_ff;
      ax_in = ax_ff; ay_in = ay_ff; rsum_in = rsum_ff;
      dxneg_in = dxneg_ff; dyneg_in = dyneg_ff; msum_in = msum_ff;
      a2_in = a2_ff; b2_in = b2_ff; r2_in = r2_ff; sum_in = sum_ff;
      dist_in = dist_ff; nxm_in = nxm_ff; nym_in = nym_ff; p_in = p_ff;
      mvi_in = mvi_ff; mvj_in = mvj_ff;
      dxi_in = dxi_ff; dyi_in = dyi_ff; dxj_in = dxj_ff; dyj_in = dyj_ff;
      rsp_valid_in = rsp_valid_ff;
      oidx_in = oidx_ff; ox_in = ox_ff; oy_in = oy_ff; olast_in = olast_ff;

      if (cmd.start) begin
         issued_in = 1'b1;
      end else if (stat.done) begin
         issued_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(MAX_BODIES)) begin
                  count_in = count_ff + CW'(1);
               end
               if (req_last_body) begin
                  n_in = count_in;
                  i_in = '0;
                  j_in = AW'(1);
                  e_in = '0;
                  state_in = (count_in < CW'(2)) ? S_EMIT_RD : S_RD_I;
               end
            end
         end
         S_RD_I: state_in = S_RD_J;
         S_RD_J: begin
            xi_in = rd_x_ff;
            yi_in = rd_y_ff;
            ri_in = rd_r_ff;
            mi_in = rd_m_ff;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            xj_in = rd_x_ff;
            yj_in = rd_y_ff;
            mj_in = rd_m_ff;
            dxneg_in = dx[32];
            dyneg_in = dy[32];
            ax_in = dx[32] ? 32'(-dx) : dx[31:0];
            ay_in = dy[32] ? 32'(-dy) : dy[31:0];
            rsum_in = {1'b0, ri_ff} + {1'b0, rd_r_ff};
            msum_in = {1'b0, mi_ff} + {1'b0, rd_m_ff};
            state_in = S_TEST;
         end
         S_TEST: begin
            if ((rsum_ff == 32'd0) || (ax_ff >= rsum_ff) || (ay_ff >= rsum_ff) ||
                (msum_ff == 17'd0)) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: begin
            a2_in = prod[63:0];
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            b2_in = prod[63:0];
            state_in = S_MUL_R;
         end
         S_MUL_R: begin
            r2_in = prod[63:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            sum_in = sum_w[63:0];
            state_in = (sum_w[64] || (sum_w[63:0] >= r2_ff)) ? S_NEXT : S_SQRT;
         end
         S_SQRT: begin
            if (stat.done) begin
               dist_in = stat.result[31:0];
               if (stat.result[31:0] == 32'd0) begin
                  nxm_in = 17'h10000;
                  nym_in = '0;
                  state_in = S_MUL_OI;
               end else begin
                  state_in = S_DIV_NX;
               end
            end
         end
         S_DIV_NX: begin
            if (stat.done) begin
               nxm_in = stat.result[16:0];
               state_in = S_DIV_NY;
            end
         end
         S_DIV_NY: begin
            if (stat.done) begin
               nym_in = stat.result[16:0];
               state_in = S_MUL_OI;
            end
         end
         S_MUL_OI: begin
            p_in = prod[47:0];
            state_in = S_DIV_MI;
         end
         S_DIV_MI: begin
            if (stat.done) begin
               mvi_in = stat.result[31:0];
               state_in = S_MUL_OJ;
            end
         end
         S_MUL_OJ: begin
            p_in = prod[47:0];
            state_in = S_DIV_MJ;
         end
         S_DIV_MJ: begin
            if (stat.done) begin
               mvj_in = stat.result[31:0];
               state_in = S_MUL_XI;
            end
         end
         S_MUL_XI: begin
            dxi_in = prod[48:0];
            state_in = S_MUL_YI;
         end
         S_MUL_YI: begin
            dyi_in = prod[48:0];
            state_in = S_MUL_XJ;
         end
         S_MUL_XJ: begin
            dxj_in = prod[48:0];
            state_in = S_MUL_YJ;
         end
         S_MUL_YJ: begin
            dyj_in = prod[48:0];
            state_in = S_WR_I;
         end
         S_WR_I: state_in = S_WR_J;
         S_WR_J: state_in = S_NEXT;
         S_NEXT: begin
            if (jn < n_ff) begin
               j_in = jn[AW-1:0];
               state_in = S_RD_I;
            end else if (i2 < n_ff) begin
               i_in = i_ff + AW'(1);
               j_in = i2[AW-1:0];
               state_in = S_RD_I;
            end else begin
               e_in = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: state_in = S_EMIT_LD;
         S_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            oidx_in = 6'(e_ff);
            ox_in = rd_x_ff;
            oy_in = rd_y_ff;
            olast_in = (en == n_ff);
            state_in = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (olast_ff) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  e_in = e_ff + AW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in; e_ff <= e_in;
      xi_ff <= xi_in; yi_ff <= yi_in; xj_ff <= xj_in; yj_ff <= yj_in;
      ri_ff <= ri_in; mi_ff <= mi_in; mj_ff <= mj_in;
      ax_ff <= ax_in; ay_ff <= ay_in; rsum_ff <= rsum_in;
      dxneg_ff <= dxneg_in; dyneg_ff <= dyneg_in; msum_ff <= msum_in;
      a2_ff <= a2_in; b2_ff <= b2_in; r2_ff <= r2_in; sum_ff <= sum_in;
      dist_ff <= dist_in; nxm_ff <= nxm_in; nym_ff <= nym_in; p_ff <= p_in;
      mvi_ff <= mvi_in; mvj_ff <= mvj_in;
      dxi_ff <= dxi_in; dyi_ff <= dyi_in; dxj_ff <= dxj_in; dyj_ff <= dyj_in;
      oidx_ff <= oidx_in; ox_ff <= ox_in; oy_ff <= oy_in; olast_ff <= olast_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_body_index  = oidx_ff;
   assign rsp_new_x       = ox_ff;
   assign rsp_new_y       = oy_ff;
   assign rsp_last_result = olast_ff;

endmodule
`default_nettype wire

### hw/rtl/cor_iter.sv
// Shared iterative unit: restoring divider (48-bit quotient) and integer
// square root (32-bit root). Depends on cor_pkg.
`default_nettype none
module cor_iter (
   input  wire                    clock,
   input  wire                    reset,
   input  cor_pkg::iter_cmd_type  cmd,
   output cor_pkg::iter_stat_type stat
);
   import cor_pkg::*;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   iter_mode_type mode_ff, mode_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [63:0]   work_ff, work_in;
   logic [34:0]   rem_ff, rem_in;
   logic [47:0]   res_ff, res_in;
   logic [31:0]   den_ff, den_in;

   logic [34:0] rem_sh;
   logic [35:0] diff;
   logic        ge;
   logic [5:0]  last_cnt;

   // One quotient bit or one root bit per cycle.
   always_comb begin
      rem_sh   = '0;
      diff     = '0;
      last_cnt = 6'(QUOT_STEPS - 1);
      unique case (mode_ff)
         ITER_DIV: begin
            rem_sh   = {rem_ff[33:0], work_ff[63]};
            diff     = {1'b0, rem_sh} - {4'b0, den_ff};
            last_cnt = 6'(QUOT_STEPS - 1);
         end
         ITER_SQRT: begin
            rem_sh   = {rem_ff[32:0], work_ff[63:62]};
            diff     = {1'b0, rem_sh} - {2'b0, res_ff[31:0], 2'b01};
            last_cnt = 6'(ROOT_STEPS - 1);
         end
         default: begin
            rem_sh = '0;
         end
      endcase
      ge = ~diff[35];
   end

   // Next-state logic of the unit.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.mode;
         cnt_in  = '0;
         work_in = cmd.num;
         rem_in  = '0;
         res_in  = '0;
         den_in  = cmd.den;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[34:0] : rem_sh;
         res_in  = {res_ff[46:0], ge};
         work_in = (mode_ff == ITER_SQRT) ? {work_ff[61:0], 2'b00} : {work_ff[62:0], 1'b0};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == last_cnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      den_ff  <= den_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = res_ff;

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for circle_overlap_resolver_top.
// Drives body words, predicts every resolved position with its own pair
// sweep in SystemVerilog, and checks each result word; needs only cor_pkg and the RTL.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BODIES = 64;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [30:0] req_radius = '0;
   logic [15:0] req_mass_value = '0;
   logic [15:0] req_size_value = '0;
   logic        req_last_body = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_body_index;
   logic [31:0] rsp_new_x;
   logic [31:0] rsp_new_y;
   logic        rsp_last_result;

   circle_overlap_resolver_top #(.MAX_BODIES(MAX_BODIES)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_radius(req_radius),
      .req_mass_value(req_mass_value), .req_size_value(req_size_value),
      .req_last_body(req_last_body),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_body_index(rsp_body_index), .rsp_new_x(rsp_new_x),
      .rsp_new_y(rsp_new_y), .rsp_last_result(rsp_last_result)
   );

   typedef struct {
      logic [5:0]  index;
      logic [31:0] x;
      logic [31:0] y;
      logic        last;
   } position_word_type;

   // Shadow of the body store kept by the predictor.
   int          shadow_x[MAX_BODIES];
   int          shadow_y[MAX_BODIES];
   int unsigned shadow_radius[MAX_BODIES];
   int unsigned shadow_mass[MAX_BODIES];
   int unsigned shadow_count = 0;

   position_word_type pending_positions[$];
   int unsigned error_count = 0;
   int unsigned bodies_sent = 0;
   int unsigned words_checked = 0;
   int unsigned sets_resolved = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_off_cycles = 0;

   // Clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver stall: a long hold-off when requested, else random stalls.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Compare each accepted result word with the oldest expected position.
   always @(posedge clock) begin
      position_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_positions.size() == 0) begin
            $error("result word with nothing expected: index %0d", rsp_body_index);
            error_count++;
         end else begin
            e = pending_positions.pop_front();
            words_checked++;
            if (rsp_body_index !== e.index) begin
               $error("body_index: expected %0d, actual %0d", e.index, rsp_body_index);
               error_count++;
            end
            if (rsp_new_x !== e.x) begin
               $error("new_x: expected %0d, actual %0d", $signed(e.x), $signed(rsp_new_x));
               error_count++;
            end
            if (rsp_new_y !== e.y) begin
               $error("new_y: expected %0d, actual %0d", $signed(e.y), $signed(rsp_new_y));
               error_count++;
            end
            if (rsp_last_result !== e.last) begin
               $error("last_result: expected %0d, actual %0d", e.last, rsp_last_result);
               error_count++;
            end
         end
      end
   end

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic int clamp_word(longint v);
      int r;
      if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -64'sd2147483648) r = 32'h8000_0000;
      else r = int'(v);
      return r;
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Normal component times move, truncated toward zero.
   function automatic longint push_amount(longint n, longint unsigned mv);
      longint m;
      m = longint'((magnitude(n) * mv) >> 16);
      return (n < 0) ? -m : m;
   endfunction

   // Push one pair apart in the shadow store.
   function automatic void separate_pair(int i, int j);
      longint dx, dy, nx, ny;
      longint unsigned rsum, ax, ay, span, overlap, msum, move_i, move_j;
      logic [65:0] dist_sq;
      logic [65:0] reach_sq;
      dx = longint'(shadow_x[j]) - longint'(shadow_x[i]);
      dy = longint'(shadow_y[j]) - longint'(shadow_y[i]);
      rsum = longint'(shadow_radius[i]) + longint'(shadow_radius[j]);
      ax = magnitude(dx);
      ay = magnitude(dy);
      if (rsum == 0 || ax >= rsum || ay >= rsum) return;
      dist_sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      reach_sq = 66'(rsum) * 66'(rsum);
      if (dist_sq >= reach_sq) return;
      msum = shadow_mass[i] + shadow_mass[j];
      if (msum == 0) return;
      span = floor_root(dist_sq[63:0]);
      if (span == 0) begin
         nx = 65536;
         ny = 0;
      end else begin
         nx = longint'((ax << 16) / span);
         ny = longint'((ay << 16) / span);
         if (dx < 0) nx = -nx;
         if (dy < 0) ny = -ny;
      end
      overlap = rsum - span;
      move_i = overlap * shadow_mass[j] / msum;
      move_j = overlap * shadow_mass[i] / msum;
      shadow_x[i] = clamp_word(longint'(shadow_x[i]) - push_amount(nx, move_i));
      shadow_y[i] = clamp_word(longint'(shadow_y[i]) - push_amount(ny, move_i));
      shadow_x[j] = clamp_word(longint'(shadow_x[j]) + push_amount(nx, move_j));
      shadow_y[j] = clamp_word(longint'(shadow_y[j]) + push_amount(ny, move_j));
   endfunction

   // Store one accepted body and, on the last one, sweep and queue positions.
   function automatic void absorb_body(logic [31:0] px, logic [31:0] py, logic [30:0] rad,
                                       logic [15:0] mv, logic [15:0] sv, logic last);
      position_word_type e;
      if (shadow_count < MAX_BODIES) begin
         shadow_x[shadow_count] = px;
         shadow_y[shadow_count] = py;
         shadow_radius[shadow_count] = 32'(rad);
         shadow_mass[shadow_count] = 32'((mv != 0) ? mv : sv);
         shadow_count++;
      end
      if (!last) return;
      for (int i = 0; i < shadow_count; i++)
         for (int j = i + 1; j < shadow_count; j++)
            separate_pair(i, j);
      for (int i = 0; i < shadow_count; i++) begin
         e.index = 6'(i);
         e.x = shadow_x[i];
         e.y = shadow_y[i];
         e.last = (i + 1 == shadow_count);
         pending_positions = {pending_positions, e};
      end
      shadow_count = 0;
      sets_resolved++;
   endfunction

   // Offer one body word, with random idle cycles first; returns at acceptance.
   task automatic send_body(logic [31:0] px, logic [31:0] py, logic [30:0] rad,
                            logic [15:0] mv, logic [15:0] sv, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_radius <= rad;
      req_mass_value <= mv;
      req_size_value <= sv;
      req_last_body <= last;
      do @(posedge clock); while (req_stall);
      bodies_sent++;
      absorb_body(px, py, rad, mv, sv, last);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A set of bodies; clustered sets overlap often, scattered ones rarely.
   task automatic send_random_set(int n, bit clustered);
      logic [31:0] bx, by;
      logic [30:0] rad;
      logic [15:0] mv;
      bx = $urandom;
      by = $urandom;
      for (int k = 0; k < n; k++) begin
         mv = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
         if (clustered) begin
            rad = 31'($urandom_range(1, 32'h0008_0000));
            send_body(bx + 32'($urandom_range(0, 32'h0010_0000)),
                      by + 32'($urandom_range(0, 32'h0010_0000)),
                      rad, mv, 16'($urandom), k == n - 1);
         end else begin
            send_body($urandom, $urandom, 31'($urandom), mv, 16'($urandom), k == n - 1);
         end
      end
   endtask

   // Field extremes and every special case of the pair rule.
   task automatic test_directed_cases();
      // Coincident centres: normal along x.
      send_body(32'h0001_0000, 32'h0002_0000, 31'h0001_0000, 16'h0100, 16'h0, 1'b0);
      send_body(32'h0001_0000, 32'h0002_0000, 31'h0002_0000, 16'h0300, 16'h0, 1'b1);
      // Zero mass sum leaves the pair unmoved.
      send_body(32'h0, 32'h0, 31'h0004_0000, 16'h0, 16'h0, 1'b0);
      send_body(32'h0001_0000, 32'h0, 31'h0004_0000, 16'h0, 16'h0, 1'b1);
      // One zero mass: that body takes the whole correction.
      send_body(32'h0, 32'h0, 31'h0004_0000, 16'h0, 16'h0, 1'b0);
      send_body(32'h0000_8000, 32'hFFFF_8000, 31'h0004_0000, 16'hFFFF, 16'hFFFF, 1'b1);
      // Zero radii never collide; size stands in for mass.
      send_body(32'h0, 32'h0, 31'h0, 16'h0, 16'h0200, 1'b0);
      send_body(32'h0, 32'h0, 31'h0, 16'h0, 16'h0100, 1'b1);
      // Saturation at the positive and negative ends.
      send_body(32'h7FFF_F000, 32'h8000_1000, 31'h4000_0000, 16'h0001, 16'h0, 1'b0);
      send_body(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 16'hFFFF, 16'h0, 1'b1);
      send_body(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h8000, 16'hFFFF, 1'b0);
      send_body(32'h8000_0001, 32'h7FFF_FFFE, 31'h7FFF_FFFF, 16'h0001, 16'h0, 1'b1);
      // Opposite corners with largest radii: too far apart.
      send_body(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 16'hFFFF, 16'h0, 1'b0);
      send_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 16'h0, 1'b1);
      // Single body set and a three body chain.
      send_body(32'h1234_5678, 32'h9ABC_DEF0, 31'h5555_5555, 16'hAAAA, 16'h5555, 1'b1);
      send_body(32'h0, 32'h0, 31'h0003_0000, 16'h0100, 16'h0, 1'b0);
      send_body(32'h0002_0000, 32'h0001_0000, 31'h0003_0000, 16'h0200, 16'h0, 1'b0);
      send_body(32'h0004_0000, 32'hFFFF_0000, 31'h0003_0000, 16'h0, 16'h0080, 1'b1);
      drain_results();
   endtask

   // Fill the store, then a dropped body that still starts the sweep.
   task automatic test_full_set();
      for (int k = 0; k < MAX_BODIES; k++) begin
         send_body(32'(k) << 20, 32'(k) << 19,
                   (k % 16 == 0) ? 31'h0008_0000 : 31'h0, 16'($urandom), 16'($urandom), 1'b0);
      end
      send_body(32'hDEAD_BEEF, 32'h0, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      drain_results();
   endtask

   // Random sets, mostly small and clustered, some scattered noise.
   task automatic test_random_sets(int unsigned idle_pct, int unsigned stall_pct, int items);
      int n;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      while (items > 0) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 5);
         send_random_set(n, $urandom_range(3) != 0);
         items -= n;
      end
      drain_results();
   endtask

   // Long receiver hold-off while further sets keep arriving.
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 5000;
      send_random_set(4, 1'b1);
      send_random_set(3, 1'b1);
      send_random_set(2, 1'b0);
      drain_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_set();
      test_random_sets(0, 0, 5);
      test_random_sets(69, 0, 5);
      test_random_sets(0, 69, 5);
      test_random_sets(20, 20, 5);
      test_output_hold_off();
      $display("Covered %0d bodies in %0d sets, %0d position words checked,",
               bodies_sent, sets_resolved, words_checked);
      $display("including a full store, saturation and a long output hold-off.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
